// ----- hw/rtl/stb_pkg.sv -----
package stb_pkg;

  localparam int TIMER_COUNT = 8;
  localparam int ID_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W = $clog2(TIMER_COUNT + 1);

  localparam int ACT_W    = 3;
  localparam int TID_W    = 8;
  localparam int PERIOD_W = 32;
  localparam int RUN_W    = 31;
  localparam int DIV_W    = 4;

  localparam logic [ACT_W-1:0] ACT_TICK       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START_ONE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_START_AUTO = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP       = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CHECK      = 3'd4;

  localparam logic [RUN_W-1:0] RUN_WRAP         = 31'h7FFF_FFFF;
  localparam logic [DIV_W-1:0] TICKS_PER_STROBE = 4'd10;

  typedef struct packed {
    logic [PERIOD_W-1:0] remaining;
    logic [PERIOD_W-1:0] reload;
    logic                done;
    logic                auto_rl;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [TID_W-1:0]    timer_id;
    logic [PERIOD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic expired;
    logic bad_id;
  } res_t;

  function automatic entry_t count_down(input entry_t e);
    entry_t o;
    o = e;
    if (e.remaining != '0) begin
      o.remaining = e.remaining - PERIOD_W'(1);
      if (o.remaining == '0) begin
        o.done = 1'b1;
        if (e.auto_rl) begin
          o.remaining = e.reload;
        end
      end
    end
    return o;
  endfunction

endpackage

// ----- hw/rtl/stb_if.sv -----
interface stb_in_if;
  logic                          valid;
  logic                          ready;
  logic [stb_pkg::ACT_W-1:0]     action;
  logic [stb_pkg::TID_W-1:0]     timer_id;
  logic [stb_pkg::PERIOD_W-1:0]  period;

  modport source (output valid, output action, output timer_id, output period, input ready);
  modport sink   (input valid, input action, input timer_id, input period, output ready);
endinterface

interface stb_out_if;
  logic                       valid;
  logic                       ready;
  logic                       expired;
  logic                       bad_id;
  logic [stb_pkg::RUN_W-1:0]  run_time;
  logic                       tenth_tick;

  modport source (output valid, output expired, output bad_id, output run_time,
                  output tenth_tick, input ready);
  modport sink   (input valid, input expired, input bad_id, input run_time,
                  input tenth_tick, output ready);
endinterface

// ----- hw/rtl/stb_ram.sv -----
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/stb_engine.sv -----
module stb_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  stb_pkg::req_t req,
  output logic          idle,
  output logic          res_valid,
  output stb_pkg::res_t res,
  input  logic          res_take
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_OP   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [stb_pkg::ACT_W-1:0]     act_r, act_nxt;
  logic [stb_pkg::PERIOD_W-1:0]  period_r, period_nxt;
  logic [stb_pkg::ID_W-1:0]      wr_addr_r, wr_addr_nxt;
  logic [stb_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          exp_r, exp_nxt;
  logic                          bad_r, bad_nxt;
  logic [stb_pkg::TIMER_COUNT-1:0] vld_r, vld_nxt;
  logic                          rvld_r;

  logic                          ram_we, ram_re;
  logic [stb_pkg::ID_W-1:0]      ram_waddr, ram_raddr;
  logic [stb_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
  stb_pkg::entry_t               ent_eff, ent_new;
  logic                          id_ok;
  logic [stb_pkg::ID_W-1:0]      req_addr;

  stb_ram #(
    .WIDTH (stb_pkg::ENTRY_W),
    .DEPTH (stb_pkg::TIMER_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // an entry never written since reset reads as all zero
  assign ent_eff  = rvld_r ? stb_pkg::entry_t'(ram_rdata) : '0;
  assign id_ok    = ({1'b0, req.timer_id} < (stb_pkg::TID_W + 1)'(stb_pkg::TIMER_COUNT));
  assign req_addr = req.timer_id[stb_pkg::ID_W-1:0];

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res.expired = exp_r;
  assign res.bad_id  = bad_r;

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    period_nxt  = period_r;
    wr_addr_nxt = wr_addr_r;
    cnt_nxt     = cnt_r;
    exp_nxt     = exp_r;
    bad_nxt     = bad_r;
    vld_nxt     = vld_r;
    ram_re      = 1'b0;
    ram_raddr   = req_addr;
    ram_we      = 1'b0;
    ram_waddr   = wr_addr_r;
    ent_new     = ent_eff;
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          act_nxt    = req.action;
          period_nxt = req.period;
          exp_nxt    = 1'b0;
          bad_nxt    = 1'b0;
          priority if (req.action == stb_pkg::ACT_TICK) begin
            ram_re      = 1'b1;
            ram_raddr   = '0;
            wr_addr_nxt = '0;
            cnt_nxt     = stb_pkg::CNT_W'(1);
            state_nxt   = S_TICK;
          end else if (req.action == stb_pkg::ACT_START_ONE ||
                       req.action == stb_pkg::ACT_START_AUTO ||
                       req.action == stb_pkg::ACT_STOP ||
                       req.action == stb_pkg::ACT_CHECK) begin
            if (id_ok) begin
              ram_re      = 1'b1;
              ram_raddr   = req_addr;
              wr_addr_nxt = req_addr;
              state_nxt   = S_OP;
            end else begin
              bad_nxt   = 1'b1;
              state_nxt = S_FIN;
            end
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_TICK: begin
        // write back the entry read last cycle, read the next one
        ram_we             = 1'b1;
        ent_new            = stb_pkg::count_down(ent_eff);
        vld_nxt[wr_addr_r] = 1'b1;
        if (cnt_r < stb_pkg::CNT_W'(stb_pkg::TIMER_COUNT)) begin
          ram_re      = 1'b1;
          ram_raddr   = cnt_r[stb_pkg::ID_W-1:0];
          wr_addr_nxt = cnt_r[stb_pkg::ID_W-1:0];
          cnt_nxt     = cnt_r + stb_pkg::CNT_W'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_OP: begin
        ram_we             = 1'b1;
        vld_nxt[wr_addr_r] = 1'b1;
        priority if (act_r == stb_pkg::ACT_START_ONE ||
                     act_r == stb_pkg::ACT_START_AUTO) begin
          ent_new.remaining = period_r;
          ent_new.reload    = period_r;
          ent_new.done      = 1'b0;
          ent_new.auto_rl   = (act_r == stb_pkg::ACT_START_AUTO);
        end else if (act_r == stb_pkg::ACT_STOP) begin
          ent_new.remaining = '0;
          ent_new.done      = 1'b0;
          ent_new.auto_rl   = 1'b0;
        end else begin
          exp_nxt      = ent_eff.done;
          ent_new.done = 1'b0;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_wdata = ent_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      if (ram_re) begin
        rvld_r <= vld_r[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    period_r  <= period_nxt;
    wr_addr_r <= wr_addr_nxt;
    cnt_r     <= cnt_nxt;
    exp_r     <= exp_nxt;
    bad_r     <= bad_nxt;
  end

`ifndef SYNTH
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write hit the same entry");

  a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> (state_r == S_IDLE))
    else $error("request while busy");

  a_bad_not_expired: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.bad_id) |-> !res.expired)
    else $error("bad id result reports expiry");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) |-> (cnt_r <= stb_pkg::CNT_W'(stb_pkg::TIMER_COUNT)))
    else $error("tick walk ran past the bank");

  a_op_leads_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OP) |=> (state_r == S_FIN))
    else $error("single-entry op did not finish");
`endif

endmodule

// ----- hw/rtl/soft_timer_bank.sv -----
// Bank of TIMER_COUNT software timers, one-shot or auto-reload.
// in_ch carries one command word per handshake (valid/ready): action,
// timer_id, period. out_ch returns exactly one result word per command:
// expired, bad_id, run_time, tenth_tick.
// All timer state sits in one RAM entry per timer (count, reload, flag,
// mode) with a registered read.
// Steps from accept to result valid:
//   tick: one RAM read-modify-write per timer, pipelined one entry per
//         cycle, then the output register;
//   start, stop, check with a good id: read, write back, then the output register;
//   bad id or unused action: the output register only.
// One command is in flight at a time; in_ch.ready is high only while the
// engine is idle, so with out_ch ready the next command can be taken in
// the same cycle as each result appears on out_ch.
// The result sits in an output register; when out_ch stalls, the finished
// command waits in the engine and no new command is taken.
// Synchronous active-low reset clears the run-time counter, the tick
// divider, the output valid flag and per-entry valid bits, so every timer
// reads as stopped with all fields zero; the RAM itself is not swept.
module soft_timer_bank (
  input  logic             clk,
  input  logic             rst_n,
  stb_in_if.sink           in_ch,
  stb_out_if.source        out_ch
);

  logic                       in_fire;
  logic                       eng_idle;
  logic                       res_valid;
  logic                       res_take;
  stb_pkg::req_t              req;
  stb_pkg::res_t              res;

  logic [stb_pkg::RUN_W-1:0]  uptime_r, uptime_nxt;
  logic [stb_pkg::DIV_W-1:0]  div_r, div_nxt;
  logic                       strobe_r, strobe_nxt;
  logic [stb_pkg::RUN_W-1:0]  up_inc;
  logic [stb_pkg::DIV_W-1:0]  div_inc;

  logic                       out_valid_r;
  logic                       out_exp_r;
  logic                       out_bad_r;
  logic [stb_pkg::RUN_W-1:0]  out_run_r;
  logic                       out_tenth_r;

  assign in_ch.ready = eng_idle;
  assign in_fire     = in_ch.valid && eng_idle;

  assign req.action   = in_ch.action;
  assign req.timer_id = in_ch.timer_id;
  assign req.period   = in_ch.period;

  stb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (in_fire),
    .req       (req),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign res_take = !out_valid_r || out_ch.ready;

  // advance run time and divider when the tick is taken
  assign up_inc  = uptime_r + stb_pkg::RUN_W'(1);
  assign div_inc = div_r + stb_pkg::DIV_W'(1);

  always_comb begin
    uptime_nxt = uptime_r;
    div_nxt    = div_r;
    strobe_nxt = strobe_r;
    if (in_fire) begin
      strobe_nxt = 1'b0;
      if (in_ch.action == stb_pkg::ACT_TICK) begin
        uptime_nxt = (up_inc == stb_pkg::RUN_WRAP) ? '0 : up_inc;
        if (div_inc >= stb_pkg::TICKS_PER_STROBE) begin
          div_nxt    = '0;
          strobe_nxt = 1'b1;
        end else begin
          div_nxt = div_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uptime_r    <= '0;
      div_r       <= '0;
      strobe_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      uptime_r <= uptime_nxt;
      div_r    <= div_nxt;
      strobe_r <= strobe_nxt;
      if (res_valid && res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_exp_r   <= res.expired;
      out_bad_r   <= res.bad_id;
      out_run_r   <= uptime_r;
      out_tenth_r <= strobe_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.expired    = out_exp_r;
  assign out_ch.bad_id     = out_bad_r;
  assign out_ch.run_time   = out_run_r;
  assign out_ch.tenth_tick = out_tenth_r;

endmodule

// ----- bench/soft_timer_bank_tb.sv -----
`timescale 1ns / 1ps

module soft_timer_bank_tb;
  import stb_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RANDOM_CMDS  = 700;
  localparam int IDLE_PCT     = 34;
  localparam int STEADY_FROM  = 400;
  localparam int STEADY_TO    = 520;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * (TIMER_COUNT + 2);
  localparam int MAX_REPORTS  = 40;

  // actions past check do nothing but report run time
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = ACT_CHECK + 1'b1;
  localparam logic [ACT_W-1:0] ACT_SPARE_MID = ACT_CHECK + 2'd2;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = '1;

  typedef struct packed {
    logic             expired;
    logic             bad_id;
    logic [RUN_W-1:0] run_time;
    logic             tenth_tick;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n;

  stb_in_if  in_ch ();
  stb_out_if out_ch ();

  soft_timer_bank DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow copy of the timer bank
  logic [PERIOD_W-1:0] t_count  [TIMER_COUNT] = '{default: '0};
  logic [PERIOD_W-1:0] t_reload [TIMER_COUNT] = '{default: '0};
  logic                t_flag   [TIMER_COUNT] = '{default: 1'b0};
  logic                t_auto   [TIMER_COUNT] = '{default: 1'b0};
  logic [RUN_W-1:0]    uptime_q   = '0;
  logic [DIV_W-1:0]    strobe_div = '0;

  req_t          cmd_queue[$];
  timer_result_t due_results[$];
  req_t          next_cmd;
  timer_result_t want;
  int            total_cmds;
  int            words_sent = 0;
  int            words_seen = 0;
  int            errors     = 0;
  int            hold_left  = 0;
  logic          hold_used  = 1'b0;
  int            quiet      = 0;
  logic          steady;

  assign steady = (words_sent >= STEADY_FROM) && (words_sent < STEADY_TO);

  function automatic timer_result_t timer_bank_step(req_t cmd);
    timer_result_t    r;
    logic             id_ok;
    logic [RUN_W-1:0] up_next;
    r = '0;
    id_ok = cmd.timer_id < TIMER_COUNT;
    case (cmd.action)
      ACT_TICK: begin
        for (int k = 0; k < TIMER_COUNT; k++) begin
          if (t_count[k] != '0) begin
            t_count[k] = t_count[k] - 1'b1;
            if (t_count[k] == '0) begin
              t_flag[k] = 1'b1;
              if (t_auto[k]) t_count[k] = t_reload[k];
            end
          end
        end
        up_next = uptime_q + 1'b1;
        uptime_q = (up_next == RUN_WRAP) ? '0 : up_next;
        strobe_div = strobe_div + 1'b1;
        if (strobe_div >= TICKS_PER_STROBE) begin
          strobe_div = '0;
          r.tenth_tick = 1'b1;
        end
      end
      ACT_START_ONE, ACT_START_AUTO: begin
        if (!id_ok) begin
          r.bad_id = 1'b1;
        end else begin
          t_count[cmd.timer_id]  = cmd.period;
          t_reload[cmd.timer_id] = cmd.period;
          t_flag[cmd.timer_id]   = 1'b0;
          t_auto[cmd.timer_id]   = (cmd.action == ACT_START_AUTO);
        end
      end
      ACT_STOP: begin
        if (!id_ok) begin
          r.bad_id = 1'b1;
        end else begin
          t_count[cmd.timer_id] = '0;
          t_flag[cmd.timer_id]  = 1'b0;
          t_auto[cmd.timer_id]  = 1'b0;
        end
      end
      ACT_CHECK: begin
        if (!id_ok) begin
          r.bad_id = 1'b1;
        end else if (t_flag[cmd.timer_id]) begin
          t_flag[cmd.timer_id] = 1'b0;
          r.expired = 1'b1;
        end
      end
      default: ;
    endcase
    r.run_time = uptime_q;
    return r;
  endfunction

  task automatic add_cmd(logic [ACT_W-1:0] action, int unsigned id,
                         int unsigned period);
    req_t c;
    c.action   = action;
    c.timer_id = TID_W'(id);
    c.period   = PERIOD_W'(period);
    cmd_queue.push_back(c);
  endtask

  task automatic check_field(string field, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      if (errors < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
      errors++;
    end
  endtask

  // driver: advance to the next word once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        next_cmd.action   = in_ch.action;
        next_cmd.timer_id = in_ch.timer_id;
        next_cmd.period   = in_ch.period;
        due_results.push_back(timer_bank_step(next_cmd));
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_queue.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_cmd = cmd_queue.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.action   <= next_cmd.action;
          in_ch.timer_id <= next_cmd.timer_id;
          in_ch.period   <= next_cmd.period;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_seen++;
        if (due_results.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t ns: unexpected result, expected none, got exp=%0b bad=%0b run=0x%0h ten=%0b",
                     $time, out_ch.expired, out_ch.bad_id, out_ch.run_time, out_ch.tenth_tick);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("expired", 64'(want.expired), 64'(out_ch.expired));
          check_field("bad_id", 64'(want.bad_id), 64'(out_ch.bad_id));
          check_field("run_time", 64'(want.run_time), 64'(out_ch.run_time));
          check_field("tenth_tick", 64'(want.tenth_tick), 64'(out_ch.tenth_tick));
        end
      end
      // hold off once for a long stretch so the bank backs up
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_used && words_seen >= HOLD_AT) begin
        hold_used    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("soft_timer_bank_tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int                  pick;
    logic [ACT_W-1:0]    act;
    int unsigned         id;
    int unsigned         per;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_TICK;
    in_ch.timer_id = '0;
    in_ch.period   = '0;
    out_ch.ready   = 1'b0;

    // directed: flags, both modes, zero period, bad ids, spare actions
    add_cmd(ACT_CHECK, 0, 0);
    add_cmd(ACT_START_ONE, 0, 1);
    add_cmd(ACT_START_AUTO, 1, 2);
    add_cmd(ACT_START_ONE, 2, 0);
    add_cmd(ACT_START_AUTO, TIMER_COUNT - 1, '1);
    add_cmd(ACT_TICK, '1, '1);
    add_cmd(ACT_CHECK, 0, 0);
    add_cmd(ACT_CHECK, 0, 0);
    add_cmd(ACT_TICK, 0, 0);
    add_cmd(ACT_CHECK, 1, 0);
    add_cmd(ACT_CHECK, 2, 0);
    add_cmd(ACT_STOP, 1, 0);
    add_cmd(ACT_START_ONE, TIMER_COUNT, 5);
    add_cmd(ACT_START_AUTO, '1, '1);
    add_cmd(ACT_STOP, 200, 0);
    add_cmd(ACT_CHECK, 128, 0);
    add_cmd(ACT_SPARE_LO, 3, 32'hA5A5_5A5A);
    add_cmd(ACT_SPARE_MID, '1, '1);
    add_cmd(ACT_SPARE_HI, 0, 7);
    add_cmd(ACT_TICK, 0, 0);
    add_cmd(ACT_CHECK, 1, 0);
    add_cmd(ACT_STOP, TIMER_COUNT - 1, 0);
    add_cmd(ACT_CHECK, TIMER_COUNT - 1, 0);

    // random: tick-heavy with short periods so timers expire often
    repeat (RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 42)      act = ACT_TICK;
      else if (pick < 54) act = ACT_START_ONE;
      else if (pick < 66) act = ACT_START_AUTO;
      else if (pick < 74) act = ACT_STOP;
      else if (pick < 95) act = ACT_CHECK;
      else                act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << TID_W) - 1)
                                       : $urandom_range(0, TIMER_COUNT - 1);
      pick = $urandom_range(0, 9);
      if (pick < 7)       per = $urandom_range(1, 12);
      else if (pick == 7) per = '0;
      else if (pick == 8) per = $urandom_range(13, 40);
      else                per = $urandom;
      add_cmd(act, id, per);
    end
    total_cmds = cmd_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (words_sent == total_cmds && due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("soft_timer_bank_tb passed");
    end else begin
      $display("soft_timer_bank_tb failed");
    end
    $finish;
  end

endmodule
